// ===== hw/rtl/afc_pkg.sv =====
// Shared constants, types and helpers for the box frustum cull test.
// Used by the channel interfaces, the plane table, the plane unit and the top level.
package afc_pkg;

  localparam int COEFF_WIDTH     = 16;
  localparam int COORD_WIDTH     = 24;
  localparam int LANE_WIDTH      = 16;
  localparam int NUM_COLS        = 4;
  localparam int NUM_PLANES      = 6;
  localparam int FRAC_BITS       = 8;
  localparam int CFG_WIDTH       = LANE_WIDTH * NUM_COLS;
  localparam int CFG_INDEX_WIDTH = $clog2(NUM_COLS);

  // A plane component is one coefficient or the sum or difference of two coefficients.
  localparam int NORM_WIDTH = COEFF_WIDTH + 1;
  localparam int PROD_WIDTH = NORM_WIDTH + COORD_WIDTH;
  // Three products and the w term.
  localparam int SUM_WIDTH  = PROD_WIDTH + 2;

  // Plane order in the table.
  localparam int PL_LEFT   = 0;
  localparam int PL_RIGHT  = 1;
  localparam int PL_TOP    = 2;
  localparam int PL_BOTTOM = 3;
  localparam int PL_NEAR   = 4;
  localparam int PL_FAR    = 5;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MATRIX_COL0 = 2'd0,
    REG_MATRIX_COL1 = 2'd1,
    REG_MATRIX_COL2 = 2'd2,
    REG_MATRIX_COL3 = 2'd3
  } cfg_reg_e;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [NORM_WIDTH-1:0]  norm_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;

  // One plane: x, y, z and w components, indexed by matrix column.
  typedef logic [NUM_COLS-1:0][NORM_WIDTH-1:0] plane_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  // Only the low COEFF_WIDTH bits of a lane carry the coefficient.
  function automatic norm_t lane_coeff(input logic [LANE_WIDTH-1:0] lane);
    logic signed [COEFF_WIDTH-1:0] c;
    c = $signed(lane[COEFF_WIDTH-1:0]);
    return norm_t'(c);
  endfunction

endpackage

// ===== hw/rtl/afc_ifs.sv =====
// Valid/ready channel interfaces for box items and cull results.
// Depends on afc_pkg for the coordinate type.
interface afc_box_if import afc_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t min_x;
  coord_t min_y;
  coord_t min_z;
  coord_t max_x;
  coord_t max_y;
  coord_t max_z;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface afc_res_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

// ===== hw/rtl/aabb_frustum_cull_test.sv =====
// Top level of the box frustum cull test: input register, plane units, result register.
// Depends on afc_pkg, afc_ifs, afc_plane_table and afc_plane_unit.
//
// Takes one axis-aligned box per cycle and returns one visible bit per box, in
// order. An accepted box passes through the input register, while the six plane
// units (three 17x24 multipliers each) form their products, then through the
// product registers, while the four-term sums and sign test feed the result
// register. With the result side always ready the block sustains one box per
// clock. The matrix columns are turned into plane components as they are
// written, so no derivation is left for run time; write it only while no box is
// in flight.
module aabb_frustum_cull_test import afc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  afc_box_if.sink              box,
  afc_res_if.source            res,
  input  logic                 cfg_we,
  input  cfg_reg_e             cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  plane_t                planes [NUM_PLANES];
  box_t                  box_q;
  logic                  s1_valid, s2_valid, res_valid, visible_q;
  logic                  s1_free, s2_free, s3_free, s1_adv;
  logic [NUM_PLANES-1:0] plane_neg;

  afc_plane_table u_table (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .planes    (planes)
  );

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    afc_plane_unit u_unit (
      .clk    (clk),
      .en     (s1_adv),
      .normal (planes[p]),
      .box    (box_q),
      .neg    (plane_neg[p])
    );
  end

  // Each stage takes a new item when it is empty or its item moves on.
  assign s3_free = !res_valid || res.ready;
  assign s2_free = !s2_valid || s3_free;
  assign s1_free = !s1_valid || s2_free;
  assign s1_adv  = s1_valid && s2_free;

  assign box.ready   = s1_free;
  assign res.valid   = res_valid;
  assign res.visible = visible_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= box.valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (s3_free) begin
        res_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && box.valid) begin
      box_q <= '{min_x: box.min_x, min_y: box.min_y, min_z: box.min_z,
                 max_x: box.max_x, max_y: box.max_y, max_z: box.max_z};
    end
    if (s3_free) begin
      visible_q <= ~|plane_neg;
    end
  end

`ifndef SYNTHESIS
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    box.valid && box.ready |=> s1_valid)
    else $error("accepted box did not reach the input register");

  a_s1_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_free |=> s2_valid)
    else $error("box left the input register but no products were held");

  a_s2_moves: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s3_free |=> res_valid)
    else $error("products were consumed but no result was registered");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid && !s2_valid && !s1_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== hw/rtl/afc_plane_table.sv =====
// Holds the six frustum planes, derived column by column from matrix writes.
// Depends on afc_pkg.
module afc_plane_table import afc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  cfg_reg_e             cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  output plane_t               planes [NUM_PLANES]
);

  norm_t r0, r1, r2, r3;
  norm_t col_next [NUM_PLANES];

  // Each plane component depends on one matrix column only, so a column
  // write refreshes that component of every plane.
  always_comb begin
    r0 = lane_coeff(cfg_data[0*LANE_WIDTH +: LANE_WIDTH]);
    r1 = lane_coeff(cfg_data[1*LANE_WIDTH +: LANE_WIDTH]);
    r2 = lane_coeff(cfg_data[2*LANE_WIDTH +: LANE_WIDTH]);
    r3 = lane_coeff(cfg_data[3*LANE_WIDTH +: LANE_WIDTH]);
    col_next[PL_LEFT]   = r3 + r0;
    col_next[PL_RIGHT]  = r3 - r0;
    col_next[PL_TOP]    = r3 - r1;
    col_next[PL_BOTTOM] = r3 + r1;
    col_next[PL_NEAR]   = r2;
    col_next[PL_FAR]    = r3 - r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        planes[p] <= '0;
      end
    end else if (cfg_we) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        planes[p][cfg_index] <= col_next[p];
      end
    end
  end

endmodule

// ===== hw/rtl/afc_plane_unit.sv =====
// Dot product of one plane with its farthest box corner, with registered products.
// Depends on afc_pkg.
module afc_plane_unit import afc_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  plane_t normal,
  input  box_t   box,
  output logic   neg
);

  coord_t cx, cy, cz;
  prod_t  prod_x, prod_y, prod_z, w_term;
  sum_t   sum;

  // The corner farthest along the normal takes max on each axis unless
  // that normal component is negative.
  always_comb begin
    cx = normal[0][NORM_WIDTH-1] ? box.min_x : box.max_x;
    cy = normal[1][NORM_WIDTH-1] ? box.min_y : box.max_y;
    cz = normal[2][NORM_WIDTH-1] ? box.min_z : box.max_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= prod_t'($signed(normal[0])) * prod_t'(cx);
      prod_y <= prod_t'($signed(normal[1])) * prod_t'(cy);
      prod_z <= prod_t'($signed(normal[2])) * prod_t'(cz);
      // w is 1.0 in the coordinate scale.
      w_term <= prod_t'($signed(normal[3])) <<< FRAC_BITS;
    end
  end

  assign sum = sum_t'(prod_x) + sum_t'(prod_y) + sum_t'(prod_z) + sum_t'(w_term);
  assign neg = sum[SUM_WIDTH-1];

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the box frustum cull test block.
// Depends on afc_pkg, the afc_box_if/afc_res_if channel interfaces and the top level RTL.
module tb;
  import afc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_DEPTH      = 3;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int PREDICT         = -1;
  localparam int COORD_MAX       = 8388607;
  localparam int COORD_MIN       = -8388608;

  // Four matrix columns, column c in bits [64c+63 : 64c].
  typedef logic [NUM_COLS-1:0][CFG_WIDTH-1:0] matrix_t;

  typedef struct {
    matrix_t m;
    box_t    b;
    int      want;
  } dir_row_t;

  localparam matrix_t MAT_IDENT = {64'h1000_0000_0000_0000, 64'h0000_1000_0000_0000,
                                   64'h0000_0000_1000_0000, 64'h0000_0000_0000_1000};
  localparam matrix_t MAT_MAX    = {16{16'h7FFF}};
  localparam matrix_t MAT_MIN    = {16{16'h8000}};
  localparam matrix_t MAT_SPREAD = {4{64'h7FFF_8000_8000_8000}};

  localparam cfg_reg_e COL_REG [NUM_COLS] = '{REG_MATRIX_COL0, REG_MATRIX_COL1,
                                               REG_MATRIX_COL2, REG_MATRIX_COL3};

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  cfg_reg_e             cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;

  afc_box_if box_ch ();
  afc_res_if res_ch ();

  aabb_frustum_cull_test dut (
    .clk       (clk),
    .rst       (rst),
    .box       (box_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  matrix_t  matrix_shadow;
  bit       visible_q[$];
  dir_row_t dir_tab[$];
  box_t     seen_box;
  bit       want_visible;
  int       box_want;
  bit       no_gap;
  bit       no_stall;
  int       fail_count;
  int       boxes_accepted;
  int       visible_seen;
  int       culled_seen;
  int       settings_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("aabb_frustum_cull_test regression: fail");
    $finish;
  end

  function automatic longint coef(matrix_t m, int c, int r);
    logic signed [COEFF_WIDTH-1:0] v;
    v = m[c][LANE_WIDTH*r +: COEFF_WIDTH];
    return longint'(v);
  endfunction

  // Component of plane p along matrix column c.
  function automatic longint plane_comp(matrix_t m, int p, int c);
    case (p)
      PL_LEFT:   return coef(m, c, 3) + coef(m, c, 0);
      PL_RIGHT:  return coef(m, c, 3) - coef(m, c, 0);
      PL_TOP:    return coef(m, c, 3) - coef(m, c, 1);
      PL_BOTTOM: return coef(m, c, 3) + coef(m, c, 1);
      PL_NEAR:   return coef(m, c, 2);
      default:   return coef(m, c, 3) - coef(m, c, 2);
    endcase
  endfunction

  function automatic bit box_visible(matrix_t m, box_t b);
    longint lo[3];
    longint hi[3];
    longint sum;
    longint n;
    bit     vis;
    lo[0] = b.min_x;
    lo[1] = b.min_y;
    lo[2] = b.min_z;
    hi[0] = b.max_x;
    hi[1] = b.max_y;
    hi[2] = b.max_z;
    vis = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      sum = plane_comp(m, p, 3) * (longint'(1) << FRAC_BITS);
      // Each axis takes the corner furthest along the normal.
      for (int a = 0; a < 3; a++) begin
        n = plane_comp(m, p, a);
        sum += n * (n < 0 ? lo[a] : hi[a]);
      end
      if (sum < 0) vis = 1'b0;
    end
    return vis;
  endfunction

  function automatic box_t mk_box(int x0, int y0, int z0, int x1, int y1, int z1);
    return '{coord_t'(x0), coord_t'(y0), coord_t'(z0), coord_t'(x1), coord_t'(y1), coord_t'(z1)};
  endfunction

  function automatic void add_row(matrix_t m, box_t b, int want);
    dir_tab.push_back('{m, b, want});
  endfunction

  function automatic matrix_t rand_matrix(int kind);
    matrix_t              m;
    logic [LANE_WIDTH-1:0] lane;
    for (int c = 0; c < NUM_COLS; c++) begin
      for (int r = 0; r < NUM_COLS; r++) begin
        case (kind)
          0: lane = LANE_WIDTH'($urandom);
          1: lane = LANE_WIDTH'($urandom_range(0, 8192) - 4096);
          2: begin
            case ($urandom_range(0, 4))
              0: lane = 16'h7FFF;
              1: lane = 16'h8000;
              2: lane = 16'h0000;
              3: lane = 16'hFFFF;
              default: lane = LANE_WIDTH'($urandom);
            endcase
          end
          default: begin
            // Near-identity with small cross terms, like a mild view transform.
            if (r == c) lane = LANE_WIDTH'(4096 + $urandom_range(0, 1024) - 512);
            else lane = LANE_WIDTH'($urandom_range(0, 512) - 256);
          end
        endcase
        m[c][LANE_WIDTH*r +: LANE_WIDTH] = lane;
      end
    end
    return m;
  endfunction

  function automatic box_t rand_box();
    int lo[3];
    int hi[3];
    int ctr;
    int half;
    int tmp;
    int pick;
    pick = $urandom_range(0, 99);
    for (int a = 0; a < 3; a++) begin
      ctr   = int'($urandom_range(0, 4095)) - 2048;
      half  = $urandom_range(0, 1023);
      lo[a] = ctr - half;
      hi[a] = ctr + half;
      if (pick >= 60 && pick < 85) begin
        lo[a] = $urandom;
        hi[a] = $urandom;
      end else if (pick >= 85 && pick < 95) begin
        if ($urandom_range(0, 1)) begin
          tmp   = lo[a];
          lo[a] = hi[a];
          hi[a] = tmp;
        end
      end else if (pick >= 95) begin
        case ($urandom_range(0, 3))
          0: lo[a] = COORD_MIN;
          1: lo[a] = COORD_MAX;
          2: lo[a] = 0;
          default: lo[a] = -1;
        endcase
        case ($urandom_range(0, 3))
          0: hi[a] = COORD_MIN;
          1: hi[a] = COORD_MAX;
          2: hi[a] = 0;
          default: hi[a] = -1;
        endcase
      end
    end
    return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  // Entered and left just after a falling edge.
  task automatic send_box(box_t b, int want);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      box_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    box_want = want;
    box_ch.valid <= 1'b1;
    box_ch.min_x <= b.min_x;
    box_ch.min_y <= b.min_y;
    box_ch.min_z <= b.min_z;
    box_ch.max_x <= b.max_x;
    box_ch.max_y <= b.max_y;
    box_ch.max_z <= b.max_z;
    do @(posedge clk); while (!box_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_boxes();
    box_ch.valid <= 1'b0;
    while (visible_q.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 1) @(negedge clk);
  endtask

  task automatic write_matrix(matrix_t m);
    for (int c = 0; c < NUM_COLS; c++) begin
      cfg_we    <= 1'b1;
      cfg_index <= COL_REG[c];
      cfg_data  <= m[c];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    matrix_shadow = m;
    settings_used++;
  endtask

  // Result side: draw a stall per item, then hold ready until one is taken.
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = no_stall ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && box_ch.valid && box_ch.ready) begin
      seen_box = '{box_ch.min_x, box_ch.min_y, box_ch.min_z,
                   box_ch.max_x, box_ch.max_y, box_ch.max_z};
      if (box_want != PREDICT) visible_q.push_back(box_want[0]);
      else visible_q.push_back(box_visible(matrix_shadow, seen_box));
      boxes_accepted++;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (visible_q.size() == 0) begin
        $error("visible: expected no item, actual %0b", res_ch.visible);
        fail_count++;
      end else begin
        want_visible = visible_q.pop_front();
        if (res_ch.visible !== want_visible) begin
          $error("visible: expected %0b, actual %0b", want_visible, res_ch.visible);
          fail_count++;
        end
      end
      if (res_ch.visible) visible_seen++;
      else culled_seen++;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_MATRIX_COL0;
    cfg_data      = '0;
    box_ch.valid  = 1'b0;
    box_ch.min_x  = '0;
    box_ch.min_y  = '0;
    box_ch.min_z  = '0;
    box_ch.max_x  = '0;
    box_ch.max_y  = '0;
    box_ch.max_z  = '0;
    matrix_shadow = '0;
    box_want      = PREDICT;
    no_gap        = 1'b0;
    no_stall      = 1'b0;

    // All-zero planes after reset never reject.
    add_row('0, mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX), 1);
    add_row('0, mk_box(0, 0, 0, 0, 0, 0), 1);
    // Identity: visible exactly when the box meets [-1,1] x [-1,1] x [0,1].
    add_row(MAT_IDENT, mk_box(0, 0, 0, 0, 0, 0), 1);
    add_row(MAT_IDENT, mk_box(-256, -256, 0, 256, 256, 256), 1);
    add_row(MAT_IDENT, mk_box(257, 0, 0, 400, 10, 10), 0);
    add_row(MAT_IDENT, mk_box(-400, 0, 0, -257, 10, 10), 0);
    add_row(MAT_IDENT, mk_box(0, 300, 0, 10, 400, 10), 0);
    add_row(MAT_IDENT, mk_box(0, -400, 0, 10, -300, 10), 0);
    add_row(MAT_IDENT, mk_box(0, 0, -512, 10, 10, -1), 0);
    add_row(MAT_IDENT, mk_box(0, 0, 257, 10, 10, 512), 0);
    add_row(MAT_IDENT, mk_box(256, 0, 0, 256, 0, 0), 1);
    add_row(MAT_IDENT,
            mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX), 1);
    // Min above max: corners are still picked per normal sign.
    add_row(MAT_IDENT, mk_box(100, 100, 100, -100, -100, -100), 0);
    add_row(MAT_IDENT, mk_box(0, 0, 200, 0, 0, 100), 1);
    add_row('1, mk_box(0, 0, 0, 0, 0, 0), PREDICT);
    add_row('1, mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX),
            PREDICT);
    add_row(MAT_MAX, mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX),
            PREDICT);
    add_row(MAT_MAX, mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX),
            PREDICT);
    add_row(MAT_MIN, mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN),
            PREDICT);
    add_row(MAT_SPREAD,
            mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX), PREDICT);
    add_row(MAT_SPREAD,
            mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN), PREDICT);
    add_row(MAT_SPREAD,
            mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX), PREDICT);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].m !== matrix_shadow) begin
        drain_boxes();
        write_matrix(dir_tab[i].m);
      end
      send_box(dir_tab[i].b, dir_tab[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_boxes();
      write_matrix(rand_matrix(p % 4));
      no_gap   = ($urandom_range(0, 3) == 0);
      no_stall = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_box(rand_box(), PREDICT);
      end
    end

    drain_boxes();
    repeat (PIPE_DEPTH + 5) @(negedge clk);

    $display("Checked %0d boxes under %0d matrix settings (reset state included as one more).",
             boxes_accepted, settings_used);
    $display("Results seen: %0d visible, %0d culled.", visible_seen, culled_seen);
    if (fail_count == 0 && visible_q.size() == 0) begin
      $display("aabb_frustum_cull_test regression: pass");
    end else begin
      $display("aabb_frustum_cull_test regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/afc_pkg.sv
hw/rtl/afc_ifs.sv
hw/rtl/afc_plane_table.sv
hw/rtl/afc_plane_unit.sv
hw/rtl/aabb_frustum_cull_test.sv
sim/tb.sv
